[src/icr_pkg.sv]
// ----------------------------------------------------------------------------
// icr_pkg: shared definitions for the integer to radix digits converter
// Constants, sequencer states and the digit to ASCII mapping.
// ----------------------------------------------------------------------------
package icr_pkg;

    // Default input width
    localparam int VALUE_WIDTH_DEF = 64;

    // Radix register
    localparam int              RADIX_W     = 6;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    // Output character
    localparam int              SYMBOL_W  = 8;
    localparam logic [SYMBOL_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [SYMBOL_W-1:0] CHAR_A    = 8'h41;
    localparam logic [SYMBOL_W-1:0] CHAR_NONE = 8'h00;
    localparam logic [RADIX_W-1:0]  DIGIT_TEN = 6'd10;

    // Dividend bits consumed by the divide step per cycle
    localparam int STEP_BITS = 8;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FETCH,
        ST_EMIT,
        ST_INVALID
    } state_t;

    // Digit value (0..35) to ASCII
    function automatic logic [SYMBOL_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [SYMBOL_W-1:0] ext;
        ext = SYMBOL_W'(d);
        if (d < DIGIT_TEN)
            return CHAR_ZERO + ext;
        else
            return CHAR_A + (ext - SYMBOL_W'(DIGIT_TEN));
    endfunction

endpackage

[src/icr_if.sv]
// ----------------------------------------------------------------------------
// icr_if: stream channels of the converter
// Input channel carries the integer, output channel one digit per beat.
// ----------------------------------------------------------------------------
interface icr_in_if #(
    parameter int VALUE_WIDTH = 64
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface icr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;
    logic       negative;
    logic       invalid;

    modport source (output valid, output symbol, output last, output negative,
                    output invalid, input ready);
    modport sink   (input valid, input symbol, input last, input negative,
                    input invalid, output ready);
endinterface

[src/icr_div_step.sv]
// ----------------------------------------------------------------------------
// icr_div_step: shared divide step
// Restoring division of STEP_BITS dividend bits by the radix, carrying a
// remainder that always stays below the radix.
// ----------------------------------------------------------------------------
module icr_div_step (
    input  logic [icr_pkg::RADIX_W-1:0]   radix,
    input  logic [icr_pkg::RADIX_W-1:0]   rem_in,
    input  logic [icr_pkg::STEP_BITS-1:0] bits_in,
    output logic [icr_pkg::STEP_BITS-1:0] quot_out,
    output logic [icr_pkg::RADIX_W-1:0]   rem_out
);
    import icr_pkg::*;

    // One quotient bit per dividend bit, MSB first
    always_comb
    begin
        logic [RADIX_W:0]   trial;
        logic [RADIX_W-1:0] rem;
        rem      = rem_in;
        quot_out = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--)
        begin
            trial = {rem, bits_in[i]};
            if (trial >= {1'b0, radix})
            begin
                quot_out[i] = 1'b1;
                trial       = trial - {1'b0, radix};
            end
            rem = trial[RADIX_W-1:0];
        end
        rem_out = rem;
    end

endmodule

[src/icr_digit_mem.sv]
// ----------------------------------------------------------------------------
// icr_digit_mem: digit store
// Holds digits least significant first; one write port, one registered read.
// ----------------------------------------------------------------------------
module icr_digit_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [icr_pkg::RADIX_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [icr_pkg::RADIX_W-1:0] rd_data
);
    import icr_pkg::*;

    logic [RADIX_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[src/integer_to_radix_digits_core.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core: signed integer to ASCII digits in radix 2..36
//
// Usage: in_ch takes one signed VALUE_WIDTH-bit value per beat. out_ch gives
// the digits of its magnitude most significant first, one ASCII character per
// beat ('0'-'9', 'A'-'Z'); the final digit has last set and every beat of a
// run has negative set when the value was negative. Zero gives one '0'. When
// the radix register holds 0, 1 or a value above 36, one beat with invalid
// and last set and symbol 0 is sent instead. cfg_we/cfg_wdata write the radix
// (reset value 10); write it only while the block is idle.
// Operation: each digit takes a pass of the shared divide step over the whole
// value (8 bits per cycle, remainder kept under the radix), then the stored
// digits stream out one per cycle from the digit memory while the receiver is
// ready; in_ch.ready is high only between items.
// Reset clears the sequencer and the output valid; the radix returns to 10.
// A stalled receiver holds the current beat in the output register and the
// sequencer waits; no beat is lost.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_core #(
    parameter int VALUE_WIDTH = icr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [icr_pkg::RADIX_W-1:0] cfg_wdata,
    icr_in_if.sink                      in_ch,
    icr_out_if.source                   out_ch
);
    import icr_pkg::*;

    localparam int CHUNKS  = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W   = CHUNKS * STEP_BITS;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int ADDR_W  = $clog2(VALUE_WIDTH);

    // Registers
    state_t                  state_reg, state_next;
    logic [RADIX_W-1:0]      radix_reg;
    logic [PAD_W-1:0]        work_reg, work_next;
    logic [RADIX_W-1:0]      rem_reg, rem_next;
    logic                    nz_reg, nz_next;
    logic [CHUNK_W-1:0]      chunk_reg, chunk_next;
    logic [ADDR_W-1:0]       dig_reg, dig_next;
    logic                    neg_reg, neg_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SYMBOL_W-1:0]     symbol_reg, symbol_next;
    logic                    last_reg, last_next;
    logic                    negative_reg, negative_next;
    logic                    invalid_reg, invalid_next;

    // Datapath wires
    logic [VALUE_WIDTH-1:0]  raw;
    logic [VALUE_WIDTH-1:0]  mag;
    logic                    raw_neg;
    logic                    radix_ok;
    logic [STEP_BITS-1:0]    quot_bits;
    logic [RADIX_W-1:0]      rem_step;
    logic                    last_chunk;
    logic                    slot_free;
    logic                    out_load;
    logic                    mem_wr_en;
    logic [ADDR_W-1:0]       mem_rd_addr;
    logic [RADIX_W-1:0]      mem_rd_data;

    // Input magnitude and sign
    assign raw      = VALUE_WIDTH'(in_ch.value);
    assign raw_neg  = raw[VALUE_WIDTH-1];
    assign mag      = raw_neg ? (~raw + VALUE_WIDTH'(1)) : raw;
    assign radix_ok = (radix_reg >= RADIX_MIN) && (radix_reg <= RADIX_MAX);

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign slot_free   = !out_valid_reg || out_ch.ready;
    assign last_chunk  = (chunk_reg == CHUNK_W'(CHUNKS - 1));

    // Shared divide step
    icr_div_step u_div_step (
        .radix    (radix_reg),
        .rem_in   (rem_reg),
        .bits_in  (work_reg[PAD_W-1 -: STEP_BITS]),
        .quot_out (quot_bits),
        .rem_out  (rem_step)
    );

    // Digit store
    icr_digit_mem #(
        .DEPTH  (VALUE_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_digit_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (dig_reg),
        .wr_data (rem_step),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (cfg_we)
            radix_reg <= cfg_wdata;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        rem_reg      <= rem_next;
        nz_reg       <= nz_next;
        chunk_reg    <= chunk_next;
        dig_reg      <= dig_next;
        neg_reg      <= neg_next;
        symbol_reg   <= symbol_next;
        last_reg     <= last_next;
        negative_reg <= negative_next;
        invalid_reg  <= invalid_next;
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        work_next     = work_reg;
        rem_next      = rem_reg;
        nz_next       = nz_reg;
        chunk_next    = chunk_reg;
        dig_next      = dig_reg;
        neg_next      = neg_reg;
        out_load      = 1'b0;
        symbol_next   = symbol_reg;
        last_next     = last_reg;
        negative_next = negative_reg;
        invalid_next  = invalid_reg;
        mem_wr_en     = 1'b0;
        mem_rd_addr   = dig_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    work_next  = PAD_W'(mag);
                    rem_next   = '0;
                    nz_next    = 1'b0;
                    chunk_next = '0;
                    dig_next   = '0;
                    neg_next   = raw_neg;
                    state_next = radix_ok ? ST_DIVIDE : ST_INVALID;
                end
            end

            ST_DIVIDE:
            begin
                // quotient bits shift in at the bottom as dividend bits leave the top
                work_next  = (work_reg << STEP_BITS) | PAD_W'(quot_bits);
                rem_next   = rem_step;
                nz_next    = nz_reg | (|quot_bits);
                chunk_next = chunk_reg + CHUNK_W'(1);
                if (last_chunk)
                begin
                    mem_wr_en  = 1'b1;
                    rem_next   = '0;
                    nz_next    = 1'b0;
                    chunk_next = '0;
                    if (nz_reg || (|quot_bits))
                        dig_next = dig_reg + ADDR_W'(1);
                    else
                        state_next = ST_FETCH;
                end
            end

            ST_FETCH:
            begin
                // read of the top digit is in flight
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    symbol_next   = digit_char(mem_rd_data);
                    last_next     = (dig_reg == '0);
                    negative_next = neg_reg;
                    invalid_next  = 1'b0;
                    mem_rd_addr   = dig_reg - ADDR_W'(1);
                    if (dig_reg == '0)
                        state_next = ST_IDLE;
                    else
                        dig_next = dig_reg - ADDR_W'(1);
                end
            end

            ST_INVALID:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    symbol_next   = CHAR_NONE;
                    last_next     = 1'b1;
                    negative_next = 1'b0;
                    invalid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register valid
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.symbol   = symbol_reg;
    assign out_ch.last     = last_reg;
    assign out_ch.negative = negative_reg;
    assign out_ch.invalid  = invalid_reg;

    // Assertions
    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> rem_reg < radix_reg)
        else $error("divide remainder not below radix");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && last_next |=> state_reg == ST_IDLE)
        else $error("sequencer busy after final beat");

    a_invalid_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.invalid |->
            out_ch.last && (out_ch.symbol == CHAR_NONE) && !out_ch.negative)
        else $error("malformed invalid beat");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ch.ready))
        else $error("output register overwritten while stalled");

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stream check of integer_to_radix_digits_core
// Feeds signed 64-bit values through the input channel under a sequence of
// radix settings (valid, boundary and unusable), predicts the ASCII digit
// beats of each value and compares every output beat field by field, with
// random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module testbench;
    import icr_pkg::*;

    localparam int VW          = 64;
    localparam int GAP_PERCENT = 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 16;

    // One output beat
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        logic                negative;
        logic                invalid;
    } digit_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [RADIX_W-1:0] cfg_wdata;

    icr_in_if #(.VALUE_WIDTH(VW)) in_ch ();
    icr_out_if out_ch ();

    integer_to_radix_digits_core #(.VALUE_WIDTH(VW)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Predictor state and bookkeeping
    logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
    logic [VW-1:0]      pending_values[$];
    digit_beat_t        expected_digits[$];
    bit                 no_gaps = 1'b0;
    int                 errors = 0;
    int                 cycles = 0;

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Digit value to its ASCII character
    function automatic logic [SYMBOL_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
        if (d < DIGIT_TEN)
            return CHAR_ZERO + SYMBOL_W'(d);
        return CHAR_A + SYMBOL_W'(d) - SYMBOL_W'(DIGIT_TEN);
    endfunction

    // Expected digit beats of one accepted value, most significant first
    function automatic void predict_digits(input logic [VW-1:0] value);
        logic [RADIX_W-1:0] digits[VW];
        logic [VW-1:0]      mag;
        logic [VW-1:0]      base;
        logic               neg;
        int                 count;
        digit_beat_t        beat;

        if (radix_setting < RADIX_MIN || radix_setting > RADIX_MAX)
        begin
            beat = '{symbol: CHAR_NONE, last: 1'b1, negative: 1'b0, invalid: 1'b1};
            expected_digits.push_back(beat);
            return;
        end
        base  = VW'(radix_setting);
        neg   = value[VW-1];
        mag   = neg ? (~value + 1'b1) : value;
        count = 0;
        do
        begin
            digits[count] = RADIX_W'(mag % base);
            mag = mag / base;
            count++;
        end while (mag != 0 && count < VW);
        for (int k = count - 1; k >= 0; k--)
        begin
            beat.symbol   = digit_ascii(digits[k]);
            beat.last     = (k == 0);
            beat.negative = neg;
            beat.invalid  = 1'b0;
            expected_digits.push_back(beat);
        end
    endfunction

    // Compare one output beat with the oldest expectation
    task automatic check_digit_beat();
        digit_beat_t want;

        if (expected_digits.size() == 0)
        begin
            $display("%0t: unexpected beat: expected none, actual symbol %h last %b neg %b inv %b",
                     $time, out_ch.symbol, out_ch.last, out_ch.negative, out_ch.invalid);
            errors++;
            return;
        end
        want = expected_digits.pop_front();
        if (out_ch.symbol !== want.symbol)
        begin
            $display("%0t: symbol mismatch: expected %h actual %h",
                     $time, want.symbol, out_ch.symbol);
            errors++;
        end
        if (out_ch.last !== want.last)
        begin
            $display("%0t: last mismatch: expected %b actual %b", $time, want.last, out_ch.last);
            errors++;
        end
        if (out_ch.negative !== want.negative)
        begin
            $display("%0t: negative mismatch: expected %b actual %b",
                     $time, want.negative, out_ch.negative);
            errors++;
        end
        if (out_ch.invalid !== want.invalid)
        begin
            $display("%0t: invalid mismatch: expected %b actual %b",
                     $time, want.invalid, out_ch.invalid);
            errors++;
        end
    endtask

    // Driver: presents the oldest pending value, holds it until accepted
    always @(posedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_digits(in_ch.value);
                void'(pending_values.pop_front());
            end
            if (in_ch.valid && !in_ch.ready)
                ; // beat still waiting
            else if (pending_values.size() != 0 &&
                     (no_gaps || $urandom_range(0, 99) >= GAP_PERCENT))
            begin
                in_ch.valid <= 1'b1;
                in_ch.value <= pending_values[0];
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Monitor: random stalls, checks every accepted digit beat
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
                check_digit_beat();
            out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Random value shaped for the current radix
    function automatic logic [VW-1:0] random_value();
        logic [VW-1:0] v;
        logic [VW-1:0] p;
        logic [VW-1:0] base;
        int            k;

        case ($urandom_range(0, 3))
            0: v = {$urandom, $urandom};
            1:
            begin
                v = VW'($urandom_range(0, 1000));
                if ($urandom_range(0, 1))
                    v = ~v + 1'b1;
            end
            2:
            begin
                v = {$urandom, $urandom} >> $urandom_range(0, VW - 1);
                if ($urandom_range(0, 1))
                    v = ~v + 1'b1;
            end
            default:
            begin
                // around a power of the radix, where the digit count changes
                base = (radix_setting < RADIX_MIN || radix_setting > RADIX_MAX)
                       ? VW'(10) : VW'(radix_setting);
                p = 1;
                k = $urandom_range(1, VW);
                while (k > 0 && p <= (64'h7FFF_FFFF_FFFF_FFFF / base))
                begin
                    p = p * base;
                    k--;
                end
                v = $urandom_range(0, 1) ? p : p - 1'b1;
                if ($urandom_range(0, 1))
                    v = ~v + 1'b1;
            end
        endcase
        return v;
    endfunction

    task automatic wait_drained();
        while (pending_values.size() != 0 || expected_digits.size() != 0)
            @(posedge clk);
    endtask

    // Radix write, only with the block idle
    task automatic set_radix(input logic [RADIX_W-1:0] r);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we    <= 1'b0;
        radix_setting = r;
    endtask

    task automatic feed_random(input int n);
        repeat (n) pending_values.push_back(random_value());
    endtask

    // Stimulus
    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.value   = '0;
        out_ch.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset radix (10): zero, signs, digit count edges, extremes
        pending_values.push_back(64'd0);
        pending_values.push_back(64'd1);
        pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        pending_values.push_back(64'd9);
        pending_values.push_back(64'd10);
        pending_values.push_back(-64'sd10);
        pending_values.push_back(64'd99);
        pending_values.push_back(64'd100);
        pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        pending_values.push_back(64'h8000_0000_0000_0000);
        pending_values.push_back(64'h8000_0000_0000_0001);
        pending_values.push_back(64'h0000_0001_0000_0000);
        pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        pending_values.push_back(64'h5555_5555_5555_5555);
        wait_drained();

        // Radix 2: most negative value gives the longest run
        set_radix(6'd2);
        pending_values.push_back(64'h8000_0000_0000_0000);
        pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        feed_random(14);

        // Radix 36: letters up to Z
        set_radix(RADIX_MAX);
        pending_values.push_back(64'd35);
        pending_values.push_back(64'd36);
        pending_values.push_back(-64'sd36);
        pending_values.push_back(64'h8000_0000_0000_0000);
        feed_random(14);

        // Back-to-back stretch with no gaps or stalls
        set_radix(6'd16);
        no_gaps = 1'b1;
        feed_random(20);
        wait_drained();
        no_gaps = 1'b0;

        set_radix(6'd8);
        feed_random(16);
        set_radix(6'd3);
        feed_random(16);
        set_radix(6'd27);
        feed_random(16);

        // Unusable radix settings
        set_radix(6'd0);
        pending_values.push_back(64'h8000_0000_0000_0000);
        feed_random(5);
        set_radix(6'd1);
        pending_values.push_back(64'd0);
        feed_random(5);
        set_radix(6'd37);
        feed_random(6);
        set_radix(6'd63);
        feed_random(6);

        repeat (3)
        begin
            set_radix(RADIX_W'($urandom_range(2, 36)));
            feed_random(18);
        end

        set_radix(RADIX_RESET);
        feed_random(14);

        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
